FILE: sv/nnd_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the nearest neighbor bgr downscaler
// no dependencies

package nnd_pkg;

    localparam int CFG_W       = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int COLOR_W     = 8;
    localparam int RESET_SIZE  = 256;
    localparam int SETTLE_W    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_HEIGHT = 1'b1;

    // cycles the ratio pipeline needs after a size change
    localparam logic [SETTLE_W-1:0] SETTLE_CYCLES = 2'd3;

    typedef struct packed {
        logic emit;
        logic eol;
        logic eof;
    } sel_t;

    typedef struct packed {
        logic [COLOR_W-1:0] byte_zero;
        logic [COLOR_W-1:0] byte_one;
        logic [COLOR_W-1:0] byte_two;
        logic               end_of_line;
        logic               end_of_frame;
    } pixel_t;

endpackage

FILE: sv/nearest_neighbour_downscale_bgr_core.sv
`timescale 1ns / 1ps
// nearest neighbor downscaler, rgb in, bgr out with line and frame marks
// a kept pixel is registered in the output buffer, then shows on out_valid
// throughput: one source pixel per cycle, limited by output backpressure and the settle stall
// reset and every size write hold in_stall while the step ratio pipeline settles
// a size write restarts the frame; reset sizes are 256 x 256
// depends on nnd_pkg, nnd_ratio, nnd_select, nnd_outbuf

module nearest_neighbour_downscale_bgr_core #(
    parameter int MAX_DIM        = 256,
    parameter int MAX_SOURCE_DIM = 4096
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [nnd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [nnd_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [nnd_pkg::COLOR_W-1:0]       red_in,
    input  logic [nnd_pkg::COLOR_W-1:0]       green_in,
    input  logic [nnd_pkg::COLOR_W-1:0]       blue_in,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [nnd_pkg::COLOR_W-1:0]       byte_zero,
    output logic [nnd_pkg::COLOR_W-1:0]       byte_one,
    output logic [nnd_pkg::COLOR_W-1:0]       byte_two,
    output logic                              end_of_line,
    output logic                              end_of_frame
);

    localparam int SRC_W = $clog2(MAX_SOURCE_DIM + 1);
    localparam int DST_W = $clog2(MAX_DIM + 1);

    logic [SRC_W-1:0] src_w, src_h;
    logic [DST_W-1:0] dst_w, dst_h;
    logic [SRC_W-1:0] col_q, row_q;
    logic [DST_W-1:0] col_r, row_r;

    logic [nnd_pkg::SETTLE_W-1:0] settle_reg;
    logic                         buf_full;
    logic                         accept;
    nnd_pkg::sel_t                sel;
    nnd_pkg::pixel_t              pix_in;
    nnd_pkg::pixel_t              pix_out;

    nnd_ratio #(
        .MAX_DIM        (MAX_DIM),
        .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
        .SRC_W          (SRC_W),
        .DST_W          (DST_W)
    ) u_ratio_w (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_write && (cfg_index == nnd_pkg::REG_SOURCE_WIDTH)),
        .wr_data  (cfg_data),
        .src_size (src_w),
        .dst_size (dst_w),
        .step_q   (col_q),
        .step_r   (col_r)
    );

    nnd_ratio #(
        .MAX_DIM        (MAX_DIM),
        .MAX_SOURCE_DIM (MAX_SOURCE_DIM),
        .SRC_W          (SRC_W),
        .DST_W          (DST_W)
    ) u_ratio_h (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_write && (cfg_index == nnd_pkg::REG_SOURCE_HEIGHT)),
        .wr_data  (cfg_data),
        .src_size (src_h),
        .dst_size (dst_h),
        .step_q   (row_q),
        .step_r   (row_r)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= nnd_pkg::SETTLE_CYCLES;
        end
        else if (cfg_write)
        begin
            settle_reg <= nnd_pkg::SETTLE_CYCLES;
        end
        else if (settle_reg != '0)
        begin
            settle_reg <= settle_reg - nnd_pkg::SETTLE_W'(1);
        end
    end

    assign in_stall = (settle_reg != '0) || buf_full;
    assign accept   = in_valid && !in_stall;

    nnd_select #(
        .SRC_W (SRC_W),
        .DST_W (DST_W)
    ) u_select (
        .clk     (clk),
        .rst_n   (rst_n),
        .restart (cfg_write),
        .accept  (accept),
        .src_w   (src_w),
        .src_h   (src_h),
        .dst_w   (dst_w),
        .dst_h   (dst_h),
        .col_q   (col_q),
        .col_r   (col_r),
        .row_q   (row_q),
        .row_r   (row_r),
        .sel     (sel)
    );

    // red and blue trade places
    assign pix_in.byte_zero    = blue_in;
    assign pix_in.byte_one     = green_in;
    assign pix_in.byte_two     = red_in;
    assign pix_in.end_of_line  = sel.eol;
    assign pix_in.end_of_frame = sel.eof;

    nnd_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && sel.emit),
        .push_data (pix_in),
        .full      (buf_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (pix_out)
    );

    assign byte_zero    = pix_out.byte_zero;
    assign byte_one     = pix_out.byte_one;
    assign byte_two     = pix_out.byte_two;
    assign end_of_line  = pix_out.end_of_line;
    assign end_of_frame = pix_out.end_of_frame;

endmodule

FILE: sv/nnd_ratio.sv
`timescale 1ns / 1ps
// one axis: size register and pipelined split of source size into step quotient/remainder
// depends on nnd_pkg

module nnd_ratio #(
    parameter int MAX_DIM        = 256,
    parameter int MAX_SOURCE_DIM = 4096,
    parameter int SRC_W          = $clog2(MAX_SOURCE_DIM + 1),
    parameter int DST_W          = $clog2(MAX_DIM + 1)
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [nnd_pkg::CFG_W-1:0]  wr_data,
    output logic [SRC_W-1:0]           src_size,
    output logic [DST_W-1:0]           dst_size,
    output logic [SRC_W-1:0]           step_q,
    output logic [DST_W-1:0]           step_r
);

    localparam int RECIP_INT = (1 << SRC_W) / MAX_DIM;
    localparam int MUL_W     = $clog2(RECIP_INT + 1);
    localparam int PROD_W    = SRC_W + MUL_W;
    localparam int QD_W      = SRC_W + DST_W;

    localparam logic [MUL_W-1:0]  RECIP   = MUL_W'(RECIP_INT);
    localparam logic [DST_W-1:0]  DIM_D   = DST_W'(MAX_DIM);
    localparam logic [31:0]       DIM32   = 32'(MAX_DIM);
    localparam logic [31:0]       SRCMAX32 = 32'(MAX_SOURCE_DIM);

    function automatic logic [SRC_W-1:0] eff_size(input logic [nnd_pkg::CFG_W-1:0] v);
        logic [SRC_W-1:0] res;
        if (v == '0)
        begin
            res = SRC_W'(1);
        end
        else if (32'(v) > SRCMAX32)
        begin
            res = SRC_W'(MAX_SOURCE_DIM);
        end
        else
        begin
            res = SRC_W'(v);
        end
        return res;
    endfunction

    logic [SRC_W-1:0]  size_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [SRC_W-1:0]  q0_reg;
    logic [SRC_W-1:0]  qd_reg;
    logic [SRC_W-1:0]  step_q_reg, step_q_next;
    logic [DST_W-1:0]  step_r_reg, step_r_next;
    logic [DST_W-1:0]  dst_reg, dst_next;

    logic [SRC_W-1:0]  q0_next;
    logic [QD_W-1:0]   qd_full;
    logic [SRC_W-1:0]  r0;
    logic [SRC_W-1:0]  r0_sub;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= eff_size(nnd_pkg::CFG_W'(nnd_pkg::RESET_SIZE));
        end
        else if (wr_en)
        begin
            size_reg <= eff_size(wr_data);
        end
    end

    assign q0_next = SRC_W'(prod_reg >> SRC_W);
    assign qd_full = QD_W'(q0_next) * QD_W'(DIM_D);
    assign r0      = size_reg - qd_reg;
    assign r0_sub  = r0 - SRC_W'(MAX_DIM);

    always_comb
    begin
        if (32'(size_reg) <= DIM32)
        begin
            step_q_next = SRC_W'(1);
            step_r_next = '0;
            dst_next    = DST_W'(size_reg);
        end
        else if (32'(r0) >= DIM32)
        begin
            step_q_next = q0_reg + SRC_W'(1);
            step_r_next = DST_W'(r0_sub);
            dst_next    = DIM_D;
        end
        else
        begin
            step_q_next = q0_reg;
            step_r_next = DST_W'(r0);
            dst_next    = DIM_D;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg   <= PROD_W'(size_reg) * PROD_W'(RECIP);
        q0_reg     <= q0_next;
        qd_reg     <= SRC_W'(qd_full);
        step_q_reg <= step_q_next;
        step_r_reg <= step_r_next;
        dst_reg    <= dst_next;
    end

    assign src_size = size_reg;
    assign dst_size = dst_reg;
    assign step_q   = step_q_reg;
    assign step_r   = step_r_reg;

endmodule

FILE: sv/nnd_select.sv
`timescale 1ns / 1ps
// raster position counters and remainder accumulators that pick the kept pixels
// depends on nnd_pkg

module nnd_select #(
    parameter int SRC_W = 13,
    parameter int DST_W = 9
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              restart,
    input  logic              accept,
    input  logic [SRC_W-1:0]  src_w,
    input  logic [SRC_W-1:0]  src_h,
    input  logic [DST_W-1:0]  dst_w,
    input  logic [DST_W-1:0]  dst_h,
    input  logic [SRC_W-1:0]  col_q,
    input  logic [DST_W-1:0]  col_r,
    input  logic [SRC_W-1:0]  row_q,
    input  logic [DST_W-1:0]  row_r,
    output nnd_pkg::sel_t     sel
);

    logic [SRC_W-1:0] src_col_reg, src_col_next;
    logic [SRC_W-1:0] src_row_reg, src_row_next;
    logic [DST_W-1:0] out_col_reg, out_col_next;
    logic [DST_W-1:0] out_row_reg, out_row_next;
    logic [DST_W-1:0] col_rem_reg, col_rem_next;
    logic [DST_W-1:0] row_rem_reg, row_rem_next;
    logic [SRC_W-1:0] nxt_col_reg, nxt_col_next;
    logic [SRC_W-1:0] nxt_row_reg, nxt_row_next;

    logic             row_sel;
    logic             emit;
    logic             last_col;
    logic             last_row;
    logic [DST_W:0]   col_sum;
    logic [DST_W:0]   row_sum;
    logic             col_carry;
    logic             row_carry;

    assign row_sel  = (src_row_reg == nxt_row_reg) && (out_row_reg < dst_h);
    assign emit     = row_sel && (src_col_reg == nxt_col_reg) && (out_col_reg < dst_w);
    assign last_col = ({1'b0, src_col_reg} + (SRC_W+1)'(1)) >= {1'b0, src_w};
    assign last_row = ({1'b0, src_row_reg} + (SRC_W+1)'(1)) >= {1'b0, src_h};

    assign col_sum   = {1'b0, col_rem_reg} + {1'b0, col_r};
    assign row_sum   = {1'b0, row_rem_reg} + {1'b0, row_r};
    assign col_carry = col_sum >= {1'b0, dst_w};
    assign row_carry = row_sum >= {1'b0, dst_h};

    assign sel.emit = emit;
    assign sel.eol  = out_col_reg == (dst_w - DST_W'(1));
    assign sel.eof  = (out_col_reg == (dst_w - DST_W'(1))) &&
                      (out_row_reg == (dst_h - DST_W'(1)));

    always_comb
    begin
        src_col_next = src_col_reg;
        src_row_next = src_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        col_rem_next = col_rem_reg;
        row_rem_next = row_rem_reg;
        nxt_col_next = nxt_col_reg;
        nxt_row_next = nxt_row_reg;

        if (emit)
        begin
            nxt_col_next = nxt_col_reg + col_q + SRC_W'(col_carry);
            col_rem_next = col_carry ? DST_W'(col_sum - {1'b0, dst_w}) : DST_W'(col_sum);
            out_col_next = out_col_reg + DST_W'(1);
        end

        if (last_col)
        begin
            src_col_next = '0;
            out_col_next = '0;
            nxt_col_next = '0;
            col_rem_next = '0;
            if (last_row)
            begin
                src_row_next = '0;
                out_row_next = '0;
                nxt_row_next = '0;
                row_rem_next = '0;
            end
            else
            begin
                if (row_sel)
                begin
                    nxt_row_next = nxt_row_reg + row_q + SRC_W'(row_carry);
                    row_rem_next = row_carry ? DST_W'(row_sum - {1'b0, dst_h})
                                             : DST_W'(row_sum);
                    out_row_next = out_row_reg + DST_W'(1);
                end
                src_row_next = src_row_reg + SRC_W'(1);
            end
        end
        else
        begin
            src_col_next = src_col_reg + SRC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            col_rem_reg <= '0;
            row_rem_reg <= '0;
            nxt_col_reg <= '0;
            nxt_row_reg <= '0;
        end
        else if (restart)
        begin
            src_col_reg <= '0;
            src_row_reg <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            col_rem_reg <= '0;
            row_rem_reg <= '0;
            nxt_col_reg <= '0;
            nxt_row_reg <= '0;
        end
        else if (accept)
        begin
            src_col_reg <= src_col_next;
            src_row_reg <= src_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            col_rem_reg <= col_rem_next;
            row_rem_reg <= row_rem_next;
            nxt_col_reg <= nxt_col_next;
            nxt_row_reg <= nxt_row_next;
        end
    end

endmodule

FILE: sv/nnd_outbuf.sv
`timescale 1ns / 1ps
// output register with one skid entry for the pixel result channel
// depends on nnd_pkg

module nnd_outbuf (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  nnd_pkg::pixel_t push_data,
    output logic            full,
    output logic            out_valid,
    input  logic            out_stall,
    output nnd_pkg::pixel_t out_data
);

    logic            main_valid_reg;
    logic            skid_valid_reg;
    nnd_pkg::pixel_t main_reg;
    nnd_pkg::pixel_t skid_reg;
    logic            main_free;

    assign main_free = !main_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_valid_reg <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            main_reg <= skid_valid_reg ? skid_reg : push_data;
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

    assign full      = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

FILE: tb/nnd_downscale_checker.sv
`timescale 1ns / 1ps
// checker for nearest_neighbour_downscale_bgr_core: watches the size port and both
// pixel channels, predicts the kept pixels and compares each output transaction
// depends on nnd_pkg

module nnd_downscale_checker #(
    parameter int MAX_DIM        = 256,
    parameter int MAX_SOURCE_DIM = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [nnd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nnd_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic [nnd_pkg::COLOR_W-1:0]   red_in,
    input  logic [nnd_pkg::COLOR_W-1:0]   green_in,
    input  logic [nnd_pkg::COLOR_W-1:0]   blue_in,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [nnd_pkg::COLOR_W-1:0]   byte_zero,
    input  logic [nnd_pkg::COLOR_W-1:0]   byte_one,
    input  logic [nnd_pkg::COLOR_W-1:0]   byte_two,
    input  logic                          end_of_line,
    input  logic                          end_of_frame,
    output int                            mismatches,
    output int                            pending
);

    logic [nnd_pkg::CFG_W-1:0] width_reg;
    logic [nnd_pkg::CFG_W-1:0] height_reg;
    int                        src_col;
    int                        src_row;
    int                        out_col;
    int                        out_row;
    int                        col_rem;
    int                        row_rem;
    int                        next_col;
    int                        next_row;
    nnd_pkg::pixel_t           expected_pixels[$];

    function automatic int effective_size(input logic [nnd_pkg::CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_SOURCE_DIM)
            return MAX_SOURCE_DIM;
        return int'(v);
    endfunction

    function automatic int capped_size(input int v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    task automatic restart_raster();
        src_col  = 0;
        src_row  = 0;
        out_col  = 0;
        out_row  = 0;
        col_rem  = 0;
        row_rem  = 0;
        next_col = 0;
        next_row = 0;
    endtask

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] wanted);
        $display("%0t: %s got %h expected %h", $time, field, got, wanted);
        mismatches++;
    endtask

    task automatic scale_pixel(input logic [nnd_pkg::COLOR_W-1:0] r,
                               input logic [nnd_pkg::COLOR_W-1:0] g,
                               input logic [nnd_pkg::COLOR_W-1:0] b);
        int              sw;
        int              sh;
        int              dw;
        int              dh;
        int              acc;
        logic            row_hit;
        nnd_pkg::pixel_t px;
        sw      = effective_size(width_reg);
        sh      = effective_size(height_reg);
        dw      = capped_size(sw);
        dh      = capped_size(sh);
        row_hit = (src_row == next_row) && (out_row < dh);
        if (row_hit && (src_col == next_col) && (out_col < dw))
        begin
            px.byte_zero    = b;
            px.byte_one     = g;
            px.byte_two     = r;
            px.end_of_line  = (out_col == dw - 1);
            px.end_of_frame = px.end_of_line && (out_row == dh - 1);
            expected_pixels.push_back(px);
            acc      = col_rem + sw;
            next_col = next_col + acc / dw;
            col_rem  = acc % dw;
            out_col  = out_col + 1;
        end
        if (src_col + 1 >= sw)
        begin
            src_col  = 0;
            out_col  = 0;
            next_col = 0;
            col_rem  = 0;
            if (src_row + 1 >= sh)
                restart_raster();
            else
            begin
                if (row_hit)
                begin
                    acc      = row_rem + sh;
                    next_row = next_row + acc / dh;
                    row_rem  = acc % dh;
                    out_row  = out_row + 1;
                end
                src_row = src_row + 1;
            end
        end
        else
            src_col = src_col + 1;
    endtask

    task automatic check_pixel();
        nnd_pkg::pixel_t want;
        if (expected_pixels.size() == 0)
        begin
            report_mismatch("unexpected pixel, byte_zero", byte_zero, 8'h00);
            return;
        end
        want = expected_pixels.pop_front();
        if (byte_zero !== want.byte_zero)
            report_mismatch("byte_zero", byte_zero, want.byte_zero);
        if (byte_one !== want.byte_one)
            report_mismatch("byte_one", byte_one, want.byte_one);
        if (byte_two !== want.byte_two)
            report_mismatch("byte_two", byte_two, want.byte_two);
        if (end_of_line !== want.end_of_line)
            report_mismatch("end_of_line", {7'd0, end_of_line}, {7'd0, want.end_of_line});
        if (end_of_frame !== want.end_of_frame)
            report_mismatch("end_of_frame", {7'd0, end_of_frame}, {7'd0, want.end_of_frame});
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = nnd_pkg::CFG_W'(nnd_pkg::RESET_SIZE);
            height_reg = nnd_pkg::CFG_W'(nnd_pkg::RESET_SIZE);
            restart_raster();
            expected_pixels.delete();
            mismatches = 0;
            pending   <= 0;
        end
        else
        begin
            if (out_valid === 1'b1 && out_stall == 1'b0)
                check_pixel();
            if (cfg_write)
            begin
                if (cfg_index == nnd_pkg::REG_SOURCE_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == nnd_pkg::REG_SOURCE_HEIGHT)
                    height_reg = cfg_data;
                restart_raster();
            end
            if (in_valid && !in_stall)
                scale_pixel(red_in, green_in, blue_in);
            pending <= expected_pixels.size();
        end
    end

endmodule

FILE: tb/nearest_neighbour_downscale_bgr_core_test.sv
`timescale 1ns / 1ps
// top of the downscaler testbench: clock, reset, size writes, pixel stimulus,
// output backpressure, watchdog and verdict
// depends on nnd_pkg, nearest_neighbour_downscale_bgr_core and nnd_downscale_checker

module nearest_neighbour_downscale_bgr_core_test;

    localparam int SCALE_LIMIT   = 256;
    localparam int SOURCE_LIMIT  = 4096;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_WAIT   = 6;
    localparam int RANDOM_PIXELS = 600;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          cfg_write = 1'b0;
    logic [nnd_pkg::CFG_IDX_W-1:0] cfg_index = nnd_pkg::REG_SOURCE_WIDTH;
    logic [nnd_pkg::CFG_W-1:0]     cfg_data  = '0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    logic [nnd_pkg::COLOR_W-1:0]   red_in    = '0;
    logic [nnd_pkg::COLOR_W-1:0]   green_in  = '0;
    logic [nnd_pkg::COLOR_W-1:0]   blue_in   = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic [nnd_pkg::COLOR_W-1:0]   byte_zero;
    logic [nnd_pkg::COLOR_W-1:0]   byte_one;
    logic [nnd_pkg::COLOR_W-1:0]   byte_two;
    logic                          end_of_line;
    logic                          end_of_frame;
    int                            mismatches;
    int                            pending;
    int                            quiet_cycles = 0;
    int                            stall_left   = 0;
    int                            stall_roll;
    bit                            steady_feed  = 1'b0;
    int                            random_fed;
    int                            shape;
    int                            frame_w;
    int                            frame_h;
    int                            frame_count;

    nearest_neighbour_downscale_bgr_core #(
        .MAX_DIM        (SCALE_LIMIT),
        .MAX_SOURCE_DIM (SOURCE_LIMIT)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_zero    (byte_zero),
        .byte_one     (byte_one),
        .byte_two     (byte_two),
        .end_of_line  (end_of_line),
        .end_of_frame (end_of_frame)
    );

    nnd_downscale_checker #(
        .MAX_DIM        (SCALE_LIMIT),
        .MAX_SOURCE_DIM (SOURCE_LIMIT)
    ) checker_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .byte_zero    (byte_zero),
        .byte_one     (byte_one),
        .byte_two     (byte_two),
        .end_of_line  (end_of_line),
        .end_of_frame (end_of_frame),
        .mismatches   (mismatches),
        .pending      (pending)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("nearest_neighbour_downscale_bgr_core verification failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // output backpressure: calm stretches, short blips and a few long stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
            stall_left = stall_left - 1;
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 10)
            begin
                out_stall <= 1'b0;
                stall_left = $urandom_range(50, 300);
            end
            else if (stall_roll < 18)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(10, 60);
            end
            else if (stall_roll < 55)
            begin
                out_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end
            else
            begin
                out_stall <= 1'b0;
                stall_left = $urandom_range(0, 3);
            end
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_pixel(input logic [nnd_pkg::COLOR_W-1:0] r,
                              input logic [nnd_pkg::COLOR_W-1:0] g,
                              input logic [nnd_pkg::COLOR_W-1:0] b);
        int gap;
        gap = steady_feed ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // quiet the input and let every kept pixel drain out
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_WAIT) @(negedge clk);
    endtask

    task automatic write_sizes(input logic [nnd_pkg::CFG_W-1:0] w,
                               input logic [nnd_pkg::CFG_W-1:0] h);
        cfg_write <= 1'b1;
        cfg_index <= nnd_pkg::REG_SOURCE_WIDTH;
        cfg_data  <= w;
        @(negedge clk);
        cfg_index <= nnd_pkg::REG_SOURCE_HEIGHT;
        cfg_data  <= h;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_frame(input int w, input int h, input int count);
        settle();
        write_sizes(w[nnd_pkg::CFG_W-1:0], h[nnd_pkg::CFG_W-1:0]);
        steady_feed = ($urandom_range(0, 3) == 0);
        repeat (count)
            send_pixel(nnd_pkg::COLOR_W'($urandom_range(0, 255)),
                       nnd_pkg::COLOR_W'($urandom_range(0, 255)),
                       nnd_pkg::COLOR_W'($urandom_range(0, 255)));
    endtask

    initial
    begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // color extremes under the reset sizes
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hff, 8'hff, 8'hff);
        send_pixel(8'haa, 8'h55, 8'haa);
        send_pixel(8'h55, 8'haa, 8'h55);
        send_pixel(8'hff, 8'h00, 8'h00);
        send_pixel(8'h00, 8'hff, 8'h00);
        send_pixel(8'h00, 8'h00, 8'hff);
        send_pixel(8'h01, 8'h80, 8'hfe);

        // zero sizes act as one pixel
        run_frame(0, 0, 4);
        // no capping, wraps into the next frame
        run_frame(3, 2, 9);
        run_frame(256, 1, 260);
        // capped in one axis, wraps into the next frame
        run_frame(257, 1, 260);
        run_frame(1, 257, 260);
        // oversized sizes clamp to the source limit
        run_frame(8191, 1, 200);
        run_frame(1, 8191, 200);
        // partial frames, restarted by the next write
        run_frame(4097, 8191, 200);
        run_frame(4096, 4096, 100);

        random_fed = 0;
        while (random_fed < RANDOM_PIXELS)
        begin
            shape = $urandom_range(0, 4);
            case (shape)
                0:
                begin
                    frame_w = $urandom_range(1, 16);
                    frame_h = $urandom_range(1, 16);
                end
                1:
                begin
                    frame_w = $urandom_range(257, 600);
                    frame_h = $urandom_range(1, 2);
                end
                2:
                begin
                    frame_w = $urandom_range(1, 2);
                    frame_h = $urandom_range(257, 600);
                end
                3:
                begin
                    frame_w = $urandom_range(0, 8191);
                    frame_h = $urandom_range(0, 8191);
                end
                default:
                begin
                    frame_w = $urandom_range(1, 256);
                    frame_h = $urandom_range(1, 4);
                end
            endcase
            if (shape == 3)
                frame_count = $urandom_range(1, 200);
            else
                frame_count = frame_w * frame_h +
                              int'($urandom_range(0, frame_w * frame_h / 4));
            if (frame_count > RANDOM_PIXELS - random_fed)
                frame_count = RANDOM_PIXELS - random_fed;
            run_frame(frame_w, frame_h, frame_count);
            random_fed = random_fed + frame_count;
        end

        settle();
        if (mismatches == 0 && pending == 0)
            $display("nearest_neighbour_downscale_bgr_core verification clean");
        else
            $display("nearest_neighbour_downscale_bgr_core verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
sv/nnd_pkg.sv
sv/nnd_ratio.sv
sv/nnd_select.sv
sv/nnd_outbuf.sv
sv/nearest_neighbour_downscale_bgr_core.sv
tb/nnd_downscale_checker.sv
tb/nearest_neighbour_downscale_bgr_core_test.sv
